// ===== rtl/mrrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrs_pkg
// Shared codes and field widths of the multilevel round-robin scheduler.
// ----------------------------------------------------------------------------
package mrrs_pkg;

    localparam int MODE_W   = 3;
    localparam int ID_W     = 6;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 2;

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SLEEP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAKEUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FINISH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_TASK = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    localparam logic CFG_MAIN_LEVEL = 1'b0;
    localparam logic CFG_NEW_LEVEL  = 1'b1;

    typedef enum logic [9:0] {
        ST_INIT0  = 10'b0000000001,
        ST_INIT1  = 10'b0000000010,
        ST_IDLE   = 10'b0000000100,
        ST_DEC    = 10'b0000001000,
        ST_ERASE  = 10'b0000010000,
        ST_PUSH   = 10'b0000100000,
        ST_RESCAN = 10'b0001000000,
        ST_FRONT  = 10'b0010000000,
        ST_DONE   = 10'b0100000000,
        ST_SPARE  = 10'b1000000000
    } state_t;

endpackage

// ===== rtl/mrrs_level_scan.sv =====
// ----------------------------------------------------------------------------
// mrrs_level_scan
// Finds the highest level whose run queue is not empty, level 0 if none.
// ----------------------------------------------------------------------------
module mrrs_level_scan #(
    parameter int NLEV = 4,
    parameter int LW   = 2
) (
    input  logic [NLEV-1:0] nonempty,
    output logic [LW-1:0]   top_level
);

    always_comb begin
        top_level = '0;
        for (int i = 0; i < NLEV; i++) begin
            if (nonempty[i]) begin
                top_level = LW'(i);
            end
        end
    end

endmodule

// ===== rtl/multilevel_round_robin_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// multilevel_round_robin_scheduler_top
// Task scheduler with one FIFO run queue per priority level.
// ----------------------------------------------------------------------------
// One event is taken at a time. Events that only touch queue heads and tails
// (tick, finish, create, sleep of the front task, wakeup of a sleeping task,
// relevel of the running task, and every error case) pass from the decode state
// through ST_FRONT to ST_DONE, with ST_RESCAN between when a level rescan
// follows. Sleep of a task that is not at the front, and relevel of such a
// task, walk its queue through the single read port of the slot memory in
// ST_ERASE (relevel then adds ST_PUSH). The next event is taken once the result
// register is loaded. After reset, and after a write of main_task_level, the
// states ST_INIT0 and ST_INIT1 seed the memories before the first event is taken.
module multilevel_round_robin_scheduler_top #(
    parameter int MAX_TASKS = 64,
    parameter int TOP_LEVEL = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // mode, task_id, level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // status, running_task, previous_task, switched, new_task_id
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);

    localparam int IW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int SW    = IW + 1;
    localparam int NLEV  = TOP_LEVEL + 1;
    localparam int LW    = $clog2(TOP_LEVEL + 1);
    localparam int DEPTH = NLEV * MAX_TASKS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [IW-1:0] wrap(input logic [SW-1:0] a);
        if (a >= SW'(MAX_TASKS)) begin
            return IW'(a - SW'(MAX_TASKS));
        end
        return IW'(a);
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l, input logic [IW-1:0] p);
        return AW'(l) * AW'(MAX_TASKS) + AW'(p);
    endfunction

    function automatic logic [LW-1:0] clamp(input logic [1:0] v);
        if (int'(v) > TOP_LEVEL) begin
            return LW'(TOP_LEVEL);
        end
        return LW'(v);
    endfunction

    // memories
    logic [IW-1:0] slots [DEPTH];
    logic [LW-1:0] lv_mem [MAX_TASKS];
    logic          sl_we;
    logic [AW-1:0] sl_waddr, sl_raddr;
    logic [IW-1:0] sl_wdata, sl_rdata_reg;
    logic          lv_we;
    logic [IW-1:0] lv_waddr, lv_raddr;
    logic [LW-1:0] lv_wdata, lv_rdata_reg;

    always_ff @(posedge aclk) begin
        if (sl_we) begin
            slots[sl_waddr] <= sl_wdata;
        end
        sl_rdata_reg <= slots[sl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lv_we) begin
            lv_mem[lv_waddr] <= lv_wdata;
        end
        lv_rdata_reg <= lv_mem[lv_raddr];
    end

    // state
    mrrs_pkg::state_t state_reg, state_next;
    logic [IW-1:0] head_reg [NLEV];
    logic [IW-1:0] head_next [NLEV];
    logic [CW-1:0] cnt_reg [NLEV];
    logic [CW-1:0] cnt_next [NLEV];
    logic [MAX_TASKS-1:0] valid_reg, valid_next, run_reg, run_next;
    logic [LW-1:0] cur_reg, cur_next, ml_reg, newlvl_reg;
    logic          lc_reg, lc_next;
    logic [CW-1:0] nid_reg, nid_next;

    logic [2:0]    mode_reg, mode_next;
    logic [5:0]    id_reg, id_next;
    logic [2:0]    lraw_reg, lraw_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [1:0]    status_reg, status_next;
    logic [IW-1:0] newid_reg, newid_next;

    logic [LW-1:0] er_lvl_reg, er_lvl_next, psh_lvl_reg, psh_lvl_next;
    logic [CW-1:0] er_rd_reg, er_rd_next, er_n_reg, er_n_next;
    logic          er_pend_reg, er_pend_next, er_push_reg, er_push_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    o_status_reg, o_status_next;
    logic [5:0]    o_run_reg, o_run_next, o_prev_reg, o_prev_next, o_nid_reg, o_nid_next;
    logic          o_sw_reg, o_sw_next;

    logic [NLEV-1:0] nonempty;
    logic [LW-1:0]   scan_top;
    logic            cfg_wr, reinit;
    logic [LW-1:0]   init_ml;

    always_comb begin
        for (int i = 0; i < NLEV; i++) begin
            nonempty[i] = (cnt_reg[i] != '0);
        end
    end

    mrrs_level_scan #(.NLEV(NLEV), .LW(LW)) u_scan (
        .nonempty (nonempty),
        .top_level(scan_top)
    );

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign reinit    = cfg_wr && (cfg_index == mrrs_pkg::CFG_MAIN_LEVEL);
    assign init_ml   = clamp(aresetn ? cfg_data : 2'd3);

    assign s_tready = (state_reg == mrrs_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, o_nid_reg, o_sw_reg, o_prev_reg, o_run_reg, o_status_reg};

    always_comb begin
        logic [IW-1:0] id_w, prev_w, now_w, hd;
        logic [LW-1:0] lvl_in, lv, l;
        logic          known, lneg;

        state_next   = state_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        valid_next   = valid_reg;
        run_next     = run_reg;
        cur_next     = cur_reg;
        lc_next      = lc_reg;
        nid_next     = nid_reg;
        mode_next    = mode_reg;
        id_next      = id_reg;
        lraw_next    = lraw_reg;
        prev_next    = prev_reg;
        status_next  = status_reg;
        newid_next   = newid_reg;
        er_lvl_next  = er_lvl_reg;
        er_rd_next   = er_rd_reg;
        er_n_next    = er_n_reg;
        er_pend_next = er_pend_reg;
        er_push_next = er_push_reg;
        psh_lvl_next = psh_lvl_reg;
        m_valid_next = m_valid_reg && !m_tready;
        o_status_next = o_status_reg;
        o_run_next   = o_run_reg;
        o_prev_next  = o_prev_reg;
        o_nid_next   = o_nid_reg;
        o_sw_next    = o_sw_reg;
        sl_we    = 1'b0;
        sl_waddr = '0;
        sl_wdata = '0;
        sl_raddr = slot_addr(cur_reg, head_reg[cur_reg]);
        lv_we    = 1'b0;
        lv_waddr = '0;
        lv_wdata = '0;
        lv_raddr = IW'(s_tdata[8:3]);

        id_w   = IW'(id_reg);
        prev_w = (cnt_reg[cur_reg] != '0) ? sl_rdata_reg : '0;
        now_w  = prev_w;
        lv     = lv_rdata_reg;
        lneg   = lraw_reg[2];
        lvl_in = clamp(lraw_reg[1:0]);
        known  = (id_reg != '0) && (int'(id_reg) < MAX_TASKS) && valid_reg[id_w];
        l      = lvl_in;
        hd     = '0;

        case (state_reg)
            mrrs_pkg::ST_INIT0: begin
                sl_we      = 1'b1;
                sl_waddr   = slot_addr(ml_reg, '0);
                sl_wdata   = IW'(1);
                lv_we      = 1'b1;
                lv_waddr   = IW'(1);
                lv_wdata   = ml_reg;
                state_next = mrrs_pkg::ST_INIT1;
            end
            mrrs_pkg::ST_INIT1: begin
                sl_we      = 1'b1;
                sl_waddr   = slot_addr('0, (ml_reg == '0) ? IW'(1) : IW'(0));
                sl_wdata   = IW'(2);
                lv_we      = 1'b1;
                lv_waddr   = IW'(2);
                lv_wdata   = '0;
                state_next = mrrs_pkg::ST_IDLE;
            end
            mrrs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = s_tdata[2:0];
                    id_next    = s_tdata[8:3];
                    lraw_next  = s_tdata[11:9];
                    state_next = mrrs_pkg::ST_DEC;
                end
            end
            mrrs_pkg::ST_DEC: begin
                prev_next   = prev_w;
                status_next = mrrs_pkg::STATUS_OK;
                newid_next  = '0;
                er_rd_next  = '0;
                er_n_next   = '0;
                er_pend_next = 1'b0;
                er_push_next = 1'b0;
                state_next  = mrrs_pkg::ST_FRONT;
                case (mode_reg)
                    mrrs_pkg::MODE_TICK: begin
                        if (cnt_reg[cur_reg] != '0) begin
                            sl_we    = 1'b1;
                            sl_waddr = slot_addr(cur_reg,
                                wrap(SW'(head_reg[cur_reg]) + SW'(cnt_reg[cur_reg])));
                            sl_wdata = prev_w;
                            head_next[cur_reg] = wrap(SW'(head_reg[cur_reg]) + SW'(1));
                            state_next = mrrs_pkg::ST_RESCAN;
                        end
                    end
                    mrrs_pkg::MODE_SLEEP: begin
                        if (!known) begin
                            status_next = mrrs_pkg::STATUS_NO_TASK;
                        end else if (run_reg[id_w]) begin
                            run_next[id_w] = 1'b0;
                            if (cnt_reg[cur_reg] != '0 && prev_w == id_w) begin
                                head_next[cur_reg] = wrap(SW'(head_reg[cur_reg]) + SW'(1));
                                cnt_next[cur_reg]  = cnt_reg[cur_reg] - CW'(1);
                                if (cnt_reg[cur_reg] == CW'(1)) begin
                                    lc_next = 1'b1;
                                end
                                state_next = mrrs_pkg::ST_RESCAN;
                            end else begin
                                er_lvl_next = lv;
                                state_next  = mrrs_pkg::ST_ERASE;
                            end
                        end
                    end
                    mrrs_pkg::MODE_WAKEUP: begin
                        if (!known) begin
                            status_next = mrrs_pkg::STATUS_NO_TASK;
                        end else if (run_reg[id_w]) begin
                            if (!lneg && lv != lvl_in) begin
                                lv_we    = 1'b1;
                                lv_waddr = id_w;
                                lv_wdata = lvl_in;
                                if (cnt_reg[cur_reg] == '0 || prev_w != id_w) begin
                                    er_lvl_next  = lv;
                                    er_push_next = 1'b1;
                                    psh_lvl_next = lvl_in;
                                    if (lvl_in > cur_reg) begin
                                        lc_next = 1'b1;
                                    end
                                    state_next = mrrs_pkg::ST_ERASE;
                                end else begin
                                    head_next[cur_reg] = wrap(SW'(head_reg[cur_reg]) + SW'(1));
                                    cnt_next[cur_reg]  = cnt_reg[cur_reg] - CW'(1);
                                    if (cnt_reg[lvl_in] < CW'(MAX_TASKS)) begin
                                        hd = (head_reg[lvl_in] == '0) ? IW'(MAX_TASKS - 1)
                                                                      : head_reg[lvl_in] - IW'(1);
                                        head_next[lvl_in] = hd;
                                        cnt_next[lvl_in]  = cnt_reg[lvl_in] + CW'(1);
                                        sl_we    = 1'b1;
                                        sl_waddr = slot_addr(lvl_in, hd);
                                        sl_wdata = id_w;
                                    end
                                    if (lvl_in < cur_reg) begin
                                        lc_next = 1'b1;
                                    end
                                    cur_next = lvl_in;
                                end
                            end
                        end else begin
                            l = lneg ? lv : lvl_in;
                            lv_we    = 1'b1;
                            lv_waddr = id_w;
                            lv_wdata = l;
                            run_next[id_w] = 1'b1;
                            if (cnt_reg[l] < CW'(MAX_TASKS)) begin
                                sl_we    = 1'b1;
                                sl_waddr = slot_addr(l, wrap(SW'(head_reg[l]) + SW'(cnt_reg[l])));
                                sl_wdata = id_w;
                                cnt_next[l] = cnt_reg[l] + CW'(1);
                            end
                            if (l > cur_reg) begin
                                lc_next = 1'b1;
                            end
                        end
                    end
                    mrrs_pkg::MODE_FINISH: begin
                        if (cnt_reg[cur_reg] == '0) begin
                            status_next = mrrs_pkg::STATUS_NO_TASK;
                        end else begin
                            head_next[cur_reg] = wrap(SW'(head_reg[cur_reg]) + SW'(1));
                            cnt_next[cur_reg]  = cnt_reg[cur_reg] - CW'(1);
                            if (cnt_reg[cur_reg] == CW'(1)) begin
                                lc_next = 1'b1;
                            end
                            valid_next[prev_w] = 1'b0;
                            run_next[prev_w]   = 1'b0;
                            state_next = mrrs_pkg::ST_RESCAN;
                        end
                    end
                    mrrs_pkg::MODE_CREATE: begin
                        if (nid_reg >= CW'(MAX_TASKS)) begin
                            status_next = mrrs_pkg::STATUS_FULL;
                        end else begin
                            newid_next = IW'(nid_reg);
                            valid_next[IW'(nid_reg)] = 1'b1;
                            run_next[IW'(nid_reg)]   = 1'b0;
                            lv_we    = 1'b1;
                            lv_waddr = IW'(nid_reg);
                            lv_wdata = newlvl_reg;
                            nid_next = nid_reg + CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            mrrs_pkg::ST_ERASE: begin
                if (er_pend_reg && sl_rdata_reg != id_w) begin
                    sl_we     = 1'b1;
                    sl_waddr  = slot_addr(er_lvl_reg,
                        wrap(SW'(head_reg[er_lvl_reg]) + SW'(er_n_reg)));
                    sl_wdata  = sl_rdata_reg;
                    er_n_next = er_n_reg + CW'(1);
                end
                if (er_rd_reg < cnt_reg[er_lvl_reg]) begin
                    sl_raddr = slot_addr(er_lvl_reg,
                        wrap(SW'(head_reg[er_lvl_reg]) + SW'(er_rd_reg)));
                    er_rd_next   = er_rd_reg + CW'(1);
                    er_pend_next = 1'b1;
                end else begin
                    er_pend_next = 1'b0;
                    if (!er_pend_reg) begin
                        cnt_next[er_lvl_reg] = er_n_reg;
                        state_next = er_push_reg ? mrrs_pkg::ST_PUSH : mrrs_pkg::ST_FRONT;
                    end
                end
            end
            mrrs_pkg::ST_PUSH: begin
                if (cnt_reg[psh_lvl_reg] < CW'(MAX_TASKS)) begin
                    sl_we    = 1'b1;
                    sl_waddr = slot_addr(psh_lvl_reg,
                        wrap(SW'(head_reg[psh_lvl_reg]) + SW'(cnt_reg[psh_lvl_reg])));
                    sl_wdata = id_w;
                    cnt_next[psh_lvl_reg] = cnt_reg[psh_lvl_reg] + CW'(1);
                end
                state_next = mrrs_pkg::ST_FRONT;
            end
            mrrs_pkg::ST_RESCAN: begin
                if (lc_reg) begin
                    cur_next = scan_top;
                    lc_next  = 1'b0;
                end
                state_next = mrrs_pkg::ST_FRONT;
            end
            mrrs_pkg::ST_FRONT: begin
                state_next = mrrs_pkg::ST_DONE;
            end
            mrrs_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_run_next    = 6'(now_w);
                    o_prev_next   = 6'(prev_reg);
                    o_sw_next     = (now_w != prev_reg);
                    o_nid_next    = 6'(newid_reg);
                    state_next    = mrrs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mrrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || reinit) begin
            state_reg <= mrrs_pkg::ST_INIT0;
            ml_reg    <= init_ml;
            cur_reg   <= init_ml;
            lc_reg    <= 1'b0;
            nid_reg   <= CW'(3);
            valid_reg <= MAX_TASKS'(6);
            run_reg   <= MAX_TASKS'(6);
            for (int i = 0; i < NLEV; i++) begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= CW'((LW'(i) == init_ml) ? 1 : 0) + CW'((i == 0) ? 1 : 0);
            end
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            lc_reg    <= lc_next;
            nid_reg   <= nid_next;
            valid_reg <= valid_next;
            run_reg   <= run_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            newlvl_reg  <= clamp(2'd1);
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr && cfg_index == mrrs_pkg::CFG_NEW_LEVEL) begin
                newlvl_reg <= clamp(cfg_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        lraw_reg     <= lraw_next;
        prev_reg     <= prev_next;
        status_reg   <= status_next;
        newid_reg    <= newid_next;
        er_lvl_reg   <= er_lvl_next;
        er_rd_reg    <= er_rd_next;
        er_n_reg     <= er_n_next;
        er_pend_reg  <= er_pend_next;
        er_push_reg  <= er_push_next;
        psh_lvl_reg  <= psh_lvl_next;
        o_status_reg <= o_status_next;
        o_run_reg    <= o_run_next;
        o_prev_reg   <= o_prev_next;
        o_sw_reg     <= o_sw_next;
        o_nid_reg    <= o_nid_next;
    end

endmodule
